>>> rtl/srsa_pkg.sv
package srsa_pkg;

    localparam int DIM_MAX    = 16;
    localparam int TBL_DEPTH  = DIM_MAX * DIM_MAX;
    localparam int TBL_AW     = $clog2(TBL_DEPTH);
    localparam int ACC_DEPTH  = 1024;
    localparam int ACC_AW     = $clog2(ACC_DEPTH);
    localparam int CNT_W      = ACC_AW + 1;
    localparam int VALUE_BITS = 48;
    localparam int FRAC_BITS  = 24;
    localparam int TARGET_W   = 11;
    localparam int DIM_W      = 5;
    localparam int IDX_W      = 4;
    localparam int TLIN_W     = IDX_W + DIM_W + 1;
    localparam int MUL_W      = 32;
    localparam int PP_W       = 2 * MUL_W;
    localparam int PROD_W     = 2 * VALUE_BITS;
    localparam int QR_W       = VALUE_BITS + 1;
    localparam int IN_DATA_W  = 136;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USER_W = 3;

    localparam logic [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_CLEAR   = 2'd1,
        ACT_SCATTER = 2'd2,
        ACT_READ    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SKIP    = 2'd1,
        ST_INVALID = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic {
        CFG_ONSITE_DIM  = 1'b0,
        CFG_INDEX_ORDER = 1'b1
    } cfg_idx_t;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_MUL  = 10'b00_0000_0010,
        S_RND  = 10'b00_0000_0100,
        S_SAT  = 10'b00_0000_1000,
        S_MARK = 10'b00_0001_0000,
        S_ENT  = 10'b00_0010_0000,
        S_UPD  = 10'b00_0100_0000,
        S_RD   = 10'b00_1000_0000,
        S_RDV  = 10'b01_0000_0000,
        S_DONE = 10'b10_0000_0000
    } state_t;

    typedef struct packed {
        logic [2:0]            pad;
        logic [ACC_AW-1:0]     read_slot;
        logic [IDX_W-1:0]      fixed_index;
        logic [VALUE_BITS-1:0] coeff;
        logic [VALUE_BITS-1:0] nz_value;
        logic [IDX_W-1:0]      nz_col;
        logic [TARGET_W-1:0]   table_target;
        logic [TBL_AW-1:0]     table_addr;
    } in_word_t;

    typedef struct packed {
        logic [2:0]            pad;
        logic [ACC_AW-1:0]     entry_target;
        logic [VALUE_BITS-1:0] entry_value;
        logic [CNT_W-1:0]      entry_count;
    } out_word_t;

    typedef struct packed {
        logic    new_entry;
        status_t status;
    } out_user_t;

endpackage

>>> rtl/sparse_row_scatter_accumulator_core.sv
// Sparse row accumulator. Load the index table (action 0) and set onsite_dim and index_order
// first, then stream one word per nonzero (action 2); each returns one result word with the
// touched entry. Clear (action 1) empties the accumulator at once: a slot mark counts only if
// it points below the entry count at an entry that holds the same target, so no sweep of the
// mark memory is needed after reset or clear. Words are handled one at a time. A scatter runs
// four partial products on one shared 32x32 multiplier, rounding and saturation, then the
// chained table, mark and entry memory reads with a write-back; an invalid target ends after
// the mark step. Load, clear and a skipped zero coefficient go straight to the result. A
// result waiting on the output register does not stop the next input word from being taken.
module sparse_row_scatter_accumulator_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // table_addr, table_target, nz_col, nz_value, coeff, fixed_index, read_slot, zero fill
    input  logic [srsa_pkg::IN_DATA_W-1:0]     s_tdata,
    // action
    input  logic [srsa_pkg::IN_USER_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // entry_count, entry_value, entry_target, zero fill
    output logic [srsa_pkg::OUT_DATA_W-1:0]    m_tdata,
    // status, new_entry
    output logic [srsa_pkg::OUT_USER_W-1:0]    m_tuser,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [srsa_pkg::DIM_W-1:0]         cfg_data
);

    localparam int VB = srsa_pkg::VALUE_BITS;

    srsa_pkg::state_t                  state_reg;
    logic [2:0]                        mul_cnt_reg;
    logic [srsa_pkg::CNT_W-1:0]        total_reg;
    logic [srsa_pkg::DIM_W-1:0]        dim_reg;
    logic                              order_reg;
    logic                              m_tvalid_reg;
    logic [srsa_pkg::OUT_DATA_W-1:0]   m_tdata_reg;
    logic [srsa_pkg::OUT_USER_W-1:0]   m_tuser_reg;

    logic [srsa_pkg::IDX_W-1:0]        col_reg;
    logic [srsa_pkg::IDX_W-1:0]        fixed_reg;
    logic [srsa_pkg::ACC_AW-1:0]       rslot_reg;
    logic [VB-1:0]                     am_reg;
    logic [VB-1:0]                     bm_reg;
    logic                              neg_reg;
    logic [srsa_pkg::PP_W-1:0]         pp_reg;
    logic [1:0]                        pp_sh_reg;
    logic [srsa_pkg::PROD_W-1:0]       acc_reg;
    logic                              ovf_reg;
    logic [srsa_pkg::QR_W-1:0]         qr_reg;
    logic [VB-1:0]                     prod_reg;
    logic [srsa_pkg::ACC_AW-1:0]       tgt_reg;
    logic [srsa_pkg::ACC_AW-1:0]       ent_reg;

    srsa_pkg::status_t                 res_status_reg;
    logic                              res_new_reg;
    logic [VB-1:0]                     res_value_reg;
    logic [srsa_pkg::ACC_AW-1:0]       res_target_reg;

    logic [srsa_pkg::TARGET_W-1:0]     tbl_mem [srsa_pkg::TBL_DEPTH];
    logic [srsa_pkg::TARGET_W-1:0]     tbl_rd_reg;
    bit   [srsa_pkg::ACC_AW-1:0]       mark_mem [srsa_pkg::ACC_DEPTH];
    logic [srsa_pkg::ACC_AW-1:0]       mark_rd_reg;
    logic [VB-1:0]                     val_mem [srsa_pkg::ACC_DEPTH];
    logic [VB-1:0]                     val_rd_reg;
    logic [srsa_pkg::ACC_AW-1:0]       tgt_mem [srsa_pkg::ACC_DEPTH];
    logic [srsa_pkg::ACC_AW-1:0]       tgt_rd_reg;

    srsa_pkg::in_word_t                in_w;
    srsa_pkg::action_t                 in_act;
    srsa_pkg::out_word_t               out_w;
    srsa_pkg::out_user_t               out_u;
    logic                              s_accept;
    logic                              out_free;

    logic [srsa_pkg::IDX_W-1:0]        major;
    logic [srsa_pkg::IDX_W-1:0]        minor;
    logic [srsa_pkg::TLIN_W-1:0]       tbl_lin;
    logic [srsa_pkg::TBL_AW-1:0]       tbl_raddr;
    logic                              tbl_we;

    logic [srsa_pkg::MUL_W-1:0]        a_sel;
    logic [srsa_pkg::MUL_W-1:0]        b_sel;
    logic [srsa_pkg::PP_W-1:0]         mul_p;
    logic [srsa_pkg::PROD_W-1:0]       pp_shifted;
    logic [srsa_pkg::QR_W-1:0]         lim;
    logic                              prod_sat;

    logic                              t_invalid;
    logic                              hit;
    logic                              full;
    logic [VB-1:0]                     sum;
    logic                              upd_append;
    logic                              val_we;
    logic [srsa_pkg::ACC_AW-1:0]       val_waddr;
    logic [VB-1:0]                     val_wdata;
    logic [srsa_pkg::ACC_AW-1:0]       ent_raddr;

    function automatic logic [VB-1:0] sat_add(input logic [VB-1:0] a, input logic [VB-1:0] b);
        logic [VB:0] s;
        s = {a[VB-1], a} + {b[VB-1], b};
        if (s[VB] != s[VB-1])
        begin
            sat_add = s[VB] ? srsa_pkg::VAL_MIN : srsa_pkg::VAL_MAX;
        end
        else
        begin
            sat_add = s[VB-1:0];
        end
    endfunction

    assign in_w     = srsa_pkg::in_word_t'(s_tdata);
    assign in_act   = srsa_pkg::action_t'(s_tuser);
    assign s_tready = (state_reg == srsa_pkg::S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // table address, wraps modulo the table depth
    assign major     = order_reg ? fixed_reg : col_reg;
    assign minor     = order_reg ? col_reg : fixed_reg;
    assign tbl_lin   = srsa_pkg::TLIN_W'(major) * srsa_pkg::TLIN_W'(dim_reg)
                       + srsa_pkg::TLIN_W'(minor);
    assign tbl_raddr = tbl_lin[srsa_pkg::TBL_AW-1:0];
    assign tbl_we    = s_accept && (in_act == srsa_pkg::ACT_LOAD);

    // partial products: step 0 lo*lo, 1 lo*hi, 2 hi*lo, 3 hi*hi
    assign a_sel      = mul_cnt_reg[1] ? srsa_pkg::MUL_W'(am_reg[VB-1:srsa_pkg::MUL_W])
                                       : am_reg[srsa_pkg::MUL_W-1:0];
    assign b_sel      = mul_cnt_reg[0] ? srsa_pkg::MUL_W'(bm_reg[VB-1:srsa_pkg::MUL_W])
                                       : bm_reg[srsa_pkg::MUL_W-1:0];
    assign mul_p      = a_sel * b_sel;
    assign pp_shifted = srsa_pkg::PROD_W'(pp_reg) << {pp_sh_reg, 5'b0};

    assign lim      = {1'b0, neg_reg ? srsa_pkg::VAL_MIN : srsa_pkg::VAL_MAX};
    assign prod_sat = ovf_reg || (qr_reg > lim);

    assign t_invalid = tbl_rd_reg[srsa_pkg::TARGET_W-1]
                       || (tbl_rd_reg >= srsa_pkg::TARGET_W'(srsa_pkg::ACC_DEPTH));
    assign hit        = ({1'b0, ent_reg} < total_reg) && (tgt_rd_reg == tgt_reg);
    assign full       = (total_reg == srsa_pkg::CNT_W'(srsa_pkg::ACC_DEPTH));
    assign sum        = sat_add(val_rd_reg, prod_reg);
    assign upd_append = (state_reg == srsa_pkg::S_UPD) && !hit && !full;
    assign val_we     = (state_reg == srsa_pkg::S_UPD) && (hit || !full);
    assign val_waddr  = hit ? ent_reg : total_reg[srsa_pkg::ACC_AW-1:0];
    assign val_wdata  = hit ? sum : prod_reg;
    assign ent_raddr  = (state_reg == srsa_pkg::S_ENT) ? mark_rd_reg : rslot_reg;

    always_comb
    begin
        out_w              = '0;
        out_w.entry_count  = total_reg;
        out_w.entry_value  = res_value_reg;
        out_w.entry_target = res_target_reg;
        out_u.new_entry    = res_new_reg;
        out_u.status       = res_status_reg;
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[in_w.table_addr] <= in_w.table_target;
        end
        tbl_rd_reg <= tbl_mem[tbl_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (upd_append)
        begin
            mark_mem[tgt_reg] <= total_reg[srsa_pkg::ACC_AW-1:0];
        end
        mark_rd_reg <= mark_mem[tbl_rd_reg[srsa_pkg::ACC_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_waddr] <= val_wdata;
        end
        val_rd_reg <= val_mem[ent_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (upd_append)
        begin
            tgt_mem[total_reg[srsa_pkg::ACC_AW-1:0]] <= tgt_reg;
        end
        tgt_rd_reg <= tgt_mem[ent_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg   <= srsa_pkg::DIM_W'(1);
            order_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (srsa_pkg::cfg_idx_t'(cfg_index))
                srsa_pkg::CFG_ONSITE_DIM:  dim_reg   <= cfg_data;
                srsa_pkg::CFG_INDEX_ORDER: order_reg <= cfg_data[0];
                default:                   dim_reg   <= dim_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= srsa_pkg::S_IDLE;
            mul_cnt_reg  <= '0;
            total_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready
                && !((state_reg == srsa_pkg::S_DONE) && out_free))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                srsa_pkg::S_IDLE:
                begin
                    if (s_accept)
                    begin
                        mul_cnt_reg <= '0;
                        case (in_act)
                            srsa_pkg::ACT_LOAD:    state_reg <= srsa_pkg::S_DONE;
                            srsa_pkg::ACT_CLEAR:
                            begin
                                total_reg <= '0;
                                state_reg <= srsa_pkg::S_DONE;
                            end
                            srsa_pkg::ACT_SCATTER:
                            begin
                                state_reg <= (in_w.coeff == '0) ? srsa_pkg::S_DONE
                                                                : srsa_pkg::S_MUL;
                            end
                            default:               state_reg <= srsa_pkg::S_RD;
                        endcase
                    end
                end
                srsa_pkg::S_MUL:
                begin
                    mul_cnt_reg <= mul_cnt_reg + 3'd1;
                    if (mul_cnt_reg == 3'd4)
                    begin
                        state_reg <= srsa_pkg::S_RND;
                    end
                end
                srsa_pkg::S_RND:  state_reg <= srsa_pkg::S_SAT;
                srsa_pkg::S_SAT:  state_reg <= srsa_pkg::S_MARK;
                srsa_pkg::S_MARK:
                begin
                    state_reg <= t_invalid ? srsa_pkg::S_DONE : srsa_pkg::S_ENT;
                end
                srsa_pkg::S_ENT:  state_reg <= srsa_pkg::S_UPD;
                srsa_pkg::S_UPD:
                begin
                    if (upd_append)
                    begin
                        total_reg <= total_reg + srsa_pkg::CNT_W'(1);
                    end
                    state_reg <= srsa_pkg::S_DONE;
                end
                srsa_pkg::S_RD:   state_reg <= srsa_pkg::S_RDV;
                srsa_pkg::S_RDV:  state_reg <= srsa_pkg::S_DONE;
                srsa_pkg::S_DONE:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= srsa_pkg::S_IDLE;
                    end
                end
                default:          state_reg <= srsa_pkg::S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == srsa_pkg::S_DONE) && out_free)
        begin
            m_tdata_reg <= out_w;
            m_tuser_reg <= out_u;
        end
        if (s_accept)
        begin
            col_reg        <= in_w.nz_col;
            fixed_reg      <= in_w.fixed_index;
            rslot_reg      <= in_w.read_slot;
            am_reg         <= in_w.coeff[VB-1] ? (VB'(0) - in_w.coeff) : in_w.coeff;
            bm_reg         <= in_w.nz_value[VB-1] ? (VB'(0) - in_w.nz_value) : in_w.nz_value;
            neg_reg        <= in_w.coeff[VB-1] ^ in_w.nz_value[VB-1];
            acc_reg        <= '0;
            res_new_reg    <= 1'b0;
            res_value_reg  <= '0;
            res_target_reg <= '0;
            res_status_reg <= ((in_act == srsa_pkg::ACT_SCATTER) && (in_w.coeff == '0))
                              ? srsa_pkg::ST_SKIP : srsa_pkg::ST_OK;
        end
        if (state_reg == srsa_pkg::S_MUL)
        begin
            pp_reg    <= mul_p;
            pp_sh_reg <= {1'b0, mul_cnt_reg[1]} + {1'b0, mul_cnt_reg[0]};
            if (mul_cnt_reg != 3'd0)
            begin
                acc_reg <= acc_reg + pp_shifted;
            end
        end
        if (state_reg == srsa_pkg::S_RND)
        begin
            ovf_reg <= |acc_reg[srsa_pkg::PROD_W-1:VB+srsa_pkg::FRAC_BITS];
            qr_reg  <= {1'b0, acc_reg[VB+srsa_pkg::FRAC_BITS-1:srsa_pkg::FRAC_BITS]}
                       + srsa_pkg::QR_W'(acc_reg[srsa_pkg::FRAC_BITS-1]);
        end
        if (state_reg == srsa_pkg::S_SAT)
        begin
            if (prod_sat)
            begin
                prod_reg <= neg_reg ? srsa_pkg::VAL_MIN : srsa_pkg::VAL_MAX;
            end
            else
            begin
                prod_reg <= neg_reg ? (VB'(0) - qr_reg[VB-1:0]) : qr_reg[VB-1:0];
            end
        end
        if (state_reg == srsa_pkg::S_MARK)
        begin
            tgt_reg <= tbl_rd_reg[srsa_pkg::ACC_AW-1:0];
            if (t_invalid)
            begin
                res_status_reg <= srsa_pkg::ST_INVALID;
            end
        end
        if (state_reg == srsa_pkg::S_ENT)
        begin
            ent_reg <= mark_rd_reg;
        end
        if (state_reg == srsa_pkg::S_UPD)
        begin
            if (hit)
            begin
                res_value_reg  <= sum;
                res_target_reg <= tgt_reg;
            end
            else if (full)
            begin
                res_status_reg <= srsa_pkg::ST_FULL;
            end
            else
            begin
                res_new_reg    <= 1'b1;
                res_value_reg  <= prod_reg;
                res_target_reg <= tgt_reg;
            end
        end
        if (state_reg == srsa_pkg::S_RDV)
        begin
            if ({1'b0, rslot_reg} < total_reg)
            begin
                res_value_reg  <= val_rd_reg;
                res_target_reg <= tgt_rd_reg;
            end
            else
            begin
                res_status_reg <= srsa_pkg::ST_INVALID;
            end
        end
    end

endmodule

>>> tb/srsa_result_checker.sv
`timescale 1ns / 100ps

module srsa_result_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [srsa_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic [srsa_pkg::IN_USER_W-1:0]     s_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [srsa_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic [srsa_pkg::OUT_USER_W-1:0]    m_tuser,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [srsa_pkg::DIM_W-1:0]         cfg_data,
    output int                                 fail_count,
    output int                                 replies_owed
);
    import srsa_pkg::*;

    localparam int QW = PROD_W - FRAC_BITS + 1;

    typedef struct packed {
        status_t               status;
        logic                  new_entry;
        logic [CNT_W-1:0]      count;
        logic [VALUE_BITS-1:0] value;
        logic [ACC_AW-1:0]     target;
    } reply_t;

    logic [TARGET_W-1:0]   slot_of_addr [TBL_DEPTH];
    bit                    mark_set     [ACC_DEPTH];
    logic [ACC_AW-1:0]     mark_pos     [ACC_DEPTH];
    logic [VALUE_BITS-1:0] acc_value    [ACC_DEPTH];
    logic [ACC_AW-1:0]     acc_target   [ACC_DEPTH];
    int unsigned           acc_count;
    logic [DIM_W-1:0]      stride;
    logic                  fixed_major;
    reply_t                replies_q [$];

    function automatic logic [VALUE_BITS-1:0] q_product(input logic [VALUE_BITS-1:0] a,
                                                        input logic [VALUE_BITS-1:0] b);
        logic [VALUE_BITS-1:0] am;
        logic [VALUE_BITS-1:0] bm;
        logic [PROD_W-1:0]     full;
        logic [QW-1:0]         q;
        logic [QW-1:0]         lim;
        logic                  neg;
        neg  = a[VALUE_BITS-1] ^ b[VALUE_BITS-1];
        am   = a[VALUE_BITS-1] ? -a : a;
        bm   = b[VALUE_BITS-1] ? -b : b;
        full = PROD_W'(am) * PROD_W'(bm);
        q    = {1'b0, full[PROD_W-1:FRAC_BITS]} + QW'(full[FRAC_BITS-1]);
        lim  = neg ? QW'(VAL_MIN) : QW'(VAL_MAX);
        if (q > lim)
            return neg ? VAL_MIN : VAL_MAX;
        return neg ? -q[VALUE_BITS-1:0] : q[VALUE_BITS-1:0];
    endfunction

    function automatic logic [VALUE_BITS-1:0] sat_sum(input logic [VALUE_BITS-1:0] a,
                                                      input logic [VALUE_BITS-1:0] b);
        logic [VALUE_BITS:0] s;
        s = {a[VALUE_BITS-1], a} + {b[VALUE_BITS-1], b};
        if (s[VALUE_BITS] != s[VALUE_BITS-1])
            return s[VALUE_BITS] ? VAL_MIN : VAL_MAX;
        return s[VALUE_BITS-1:0];
    endfunction

    function automatic reply_t predict_entry(input action_t act, input in_word_t w);
        reply_t                r;
        int unsigned           a;
        logic [TARGET_W-1:0]   tgt;
        logic [ACC_AW-1:0]     slot;
        logic [ACC_AW-1:0]     e;
        logic [VALUE_BITS-1:0] prod;
        r = '0;
        case (act)
            ACT_LOAD:
                slot_of_addr[w.table_addr] = w.table_target;
            ACT_CLEAR:
            begin
                foreach (mark_set[i])
                    mark_set[i] = 1'b0;
                acc_count = 0;
            end
            ACT_SCATTER:
            begin
                if (w.coeff == '0)
                    r.status = ST_SKIP;
                else
                begin
                    a = fixed_major ? w.fixed_index * stride + w.nz_col
                                    : w.nz_col * stride + w.fixed_index;
                    tgt  = slot_of_addr[a % TBL_DEPTH];
                    slot = tgt[ACC_AW-1:0];
                    if (tgt[TARGET_W-1])
                        r.status = ST_INVALID;
                    else
                    begin
                        prod = q_product(w.coeff, w.nz_value);
                        if (mark_set[slot])
                        begin
                            e = mark_pos[slot];
                            acc_value[e] = sat_sum(acc_value[e], prod);
                            r.value  = acc_value[e];
                            r.target = slot;
                        end
                        else if (acc_count >= ACC_DEPTH)
                            r.status = ST_FULL;
                        else
                        begin
                            mark_set[slot]        = 1'b1;
                            mark_pos[slot]        = ACC_AW'(acc_count);
                            acc_value[acc_count]  = prod;
                            acc_target[acc_count] = slot;
                            acc_count++;
                            r.new_entry = 1'b1;
                            r.value     = prod;
                            r.target    = slot;
                        end
                    end
                end
            end
            default:
            begin
                if (w.read_slot < acc_count)
                begin
                    r.value  = acc_value[w.read_slot];
                    r.target = acc_target[w.read_slot];
                end
                else
                    r.status = ST_INVALID;
            end
        endcase
        r.count = CNT_W'(acc_count);
        return r;
    endfunction

    function automatic void flag(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (fail_count < 100)
            $error("%s: expected %0h, got %0h", field, want, got);
        fail_count++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reply_t    want;
        out_word_t od;
        out_user_t ou;
        if (!rst_n)
        begin
            foreach (slot_of_addr[i])
                slot_of_addr[i] = '0;
            foreach (mark_set[i])
                mark_set[i] = 1'b0;
            acc_count   = 0;
            stride      = DIM_W'(1);
            fixed_major = 1'b0;
            fail_count  = 0;
            replies_q.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                od = m_tdata;
                ou = m_tuser;
                if (replies_q.size() == 0)
                begin
                    if (fail_count < 100)
                        $error("result word with no prediction pending");
                    fail_count++;
                end
                else
                begin
                    want = replies_q.pop_front();
                    if (ou.status !== want.status)
                        flag("status", want.status, ou.status);
                    if (ou.new_entry !== want.new_entry)
                        flag("new_entry", want.new_entry, ou.new_entry);
                    if (od.entry_count !== want.count)
                        flag("entry_count", want.count, od.entry_count);
                    if (od.entry_value !== want.value)
                        flag("entry_value", want.value, od.entry_value);
                    if (od.entry_target !== want.target)
                        flag("entry_target", want.target, od.entry_target);
                end
            end
            if (s_tvalid && s_tready)
                replies_q.push_back(predict_entry(action_t'(s_tuser), in_word_t'(s_tdata)));
            if (cfg_we)
            begin
                if (cfg_index == CFG_ONSITE_DIM)
                    stride = cfg_data;
                else
                    fixed_major = cfg_data[0];
            end
        end
        replies_owed = replies_q.size();
    end

endmodule

>>> tb/sparse_row_scatter_accumulator_core_test.sv
`timescale 1ns / 100ps

module sparse_row_scatter_accumulator_core_test;
    import srsa_pkg::*;

    localparam logic [VALUE_BITS-1:0] Q_ONE = 48'h0000_0100_0000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [IN_USER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [DIM_W-1:0]      cfg_data;
    int                    fail_count;
    int                    replies_owed;

    bit                    tbl_loaded [TBL_DEPTH];
    logic [DIM_W-1:0]      cur_dim;
    logic                  cur_order;
    int                    burst_left;
    logic [15:0]           ready_pat = '1;
    int                    pat_age = 0;

    sparse_row_scatter_accumulator_core uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    srsa_result_checker result_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .replies_owed (replies_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            ready_pat <= '1;
            pat_age   <= 0;
        end
        else
        begin
            m_tready <= ready_pat[0];
            if (pat_age == 63)
            begin
                pat_age <= 0;
                case ($urandom_range(0, 3))
                    0:       ready_pat <= '1;
                    1:       ready_pat <= 16'($urandom) | 16'h0001;
                    2:       ready_pat <= 16'($urandom & $urandom) | 16'h0001;
                    default: ready_pat <= 16'h0101;
                endcase
            end
            else
            begin
                pat_age   <= pat_age + 1;
                ready_pat <= {ready_pat[0], ready_pat[15:1]};
            end
        end
    end

    function automatic in_word_t rand_word();
        in_word_t w;
        w = IN_DATA_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
        w.pad = '0;
        return w;
    endfunction

    function automatic logic [VALUE_BITS-1:0] rand_q();
        logic signed [VALUE_BITS-1:0] r;
        r = VALUE_BITS'({$urandom, $urandom});
        case ($urandom_range(0, 11))
            0:       r = '0;
            1:       r = VAL_MAX;
            2:       r = VAL_MIN;
            3:       r = Q_ONE;
            4:       r = -Q_ONE;
            5:       r = r >>> (VALUE_BITS - FRAC_BITS + $urandom_range(0, 8));
            default: r = r >>> $urandom_range(0, 40);
        endcase
        return r;
    endfunction

    function automatic logic [TARGET_W-1:0] pick_target(input int pool);
        if ($urandom_range(0, 15) == 0)
            return '1;
        return TARGET_W'($urandom_range(0, pool));
    endfunction

    function automatic logic [TBL_AW-1:0] tbl_addr(input logic [IDX_W-1:0] col,
                                                   input logic [IDX_W-1:0] fixed);
        int unsigned a;
        a = cur_order ? fixed * cur_dim + col : col * cur_dim + fixed;
        return a[TBL_AW-1:0];
    endfunction

    task automatic send_word(input action_t act, input in_word_t w);
        int gap;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(0, 10);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tuser  <= act;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic load_slot(input logic [TBL_AW-1:0] a, input logic [TARGET_W-1:0] t);
        in_word_t w;
        w = rand_word();
        w.table_addr   = a;
        w.table_target = t;
        tbl_loaded[a]  = 1'b1;
        send_word(ACT_LOAD, w);
    endtask

    task automatic clear_marks();
        send_word(ACT_CLEAR, rand_word());
    endtask

    task automatic read_entry(input logic [ACC_AW-1:0] slot);
        in_word_t w;
        w = rand_word();
        w.read_slot = slot;
        send_word(ACT_READ, w);
    endtask

    // load the table entry first if this address was never written
    task automatic scatter_nz(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] fixed,
                              input logic [VALUE_BITS-1:0] cf,
                              input logic [VALUE_BITS-1:0] val, input int pool);
        in_word_t          w;
        logic [TBL_AW-1:0] a;
        a = tbl_addr(col, fixed);
        if (!tbl_loaded[a])
            load_slot(a, pick_target(pool));
        w = rand_word();
        w.nz_col      = col;
        w.fixed_index = fixed;
        w.coeff       = cf;
        w.nz_value    = val;
        send_word(ACT_SCATTER, w);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (replies_owed != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic set_config(input logic [DIM_W-1:0] dim, input logic order);
        cur_dim   = dim;
        cur_order = order;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ONSITE_DIM;
        cfg_data  <= dim;
        @(posedge clk);
        cfg_index <= CFG_INDEX_ORDER;
        cfg_data  <= DIM_W'(order);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        int                    pool;
        int                    pick;
        rst_n      <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= ACT_LOAD;
        cfg_we     <= 1'b0;
        cfg_index  <= CFG_ONSITE_DIM;
        cfg_data   <= '0;
        cur_dim    = DIM_W'(1);
        cur_order  = 1'b0;
        burst_left = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_config(5'd16, 1'b0);
        read_entry(10'd0);
        load_slot(8'd0, 11'd5);
        load_slot(8'd1, 11'd1023);
        load_slot(8'd2, '1);
        load_slot(8'd255, 11'd0);
        scatter_nz(4'd0, 4'd0, Q_ONE, VAL_MAX, 1023);
        scatter_nz(4'd0, 4'd0, Q_ONE, VAL_MAX, 1023);
        scatter_nz(4'd0, 4'd1, VAL_MAX, VAL_MAX, 1023);
        scatter_nz(4'd0, 4'd1, VAL_MIN, VAL_MAX, 1023);
        scatter_nz(4'd0, 4'd1, VAL_MIN, VAL_MIN, 1023);
        scatter_nz(4'd0, 4'd0, '0, VAL_MIN, 1023);
        scatter_nz(4'd0, 4'd2, Q_ONE, Q_ONE, 1023);
        scatter_nz(4'd15, 4'd15, 48'd1, 48'h80_0000, 1023);
        scatter_nz(4'd15, 4'd15, '1, 48'h80_0000, 1023);
        read_entry(10'd0);
        read_entry(10'd2);
        read_entry(10'd3);
        clear_marks();
        read_entry(10'd0);
        scatter_nz(4'd0, 4'd1, Q_ONE, VAL_MIN, 1023);

        for (int ph = 0; ph < 8; ph++)
        begin
            wait_idle();
            case (ph)
                0:       set_config(5'd0, 1'b0);
                1:       set_config(5'd31, 1'b1);
                2:       set_config(5'd1, 1'b1);
                3:       set_config(5'd16, 1'b0);
                default: set_config(DIM_W'($urandom_range(0, 31)), 1'($urandom));
            endcase
            pool = (ph % 3 == 0) ? 7 : (ph % 3 == 1) ? 63 : 1023;
            for (int n = 0; n < 220; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 62)
                    scatter_nz(IDX_W'($urandom), IDX_W'($urandom), rand_q(), rand_q(), pool);
                else if (pick < 77)
                    load_slot(TBL_AW'($urandom), pick_target(pool));
                else if (pick < 94)
                    read_entry(($urandom_range(0, 4) == 0) ? ACC_AW'($urandom)
                                                           : ACC_AW'($urandom_range(0, 40)));
                else
                    clear_marks();
            end
        end

        wait_idle();
        set_config(5'd16, 1'b1);
        clear_marks();
        for (int n = 0; n < 10; n++)
            scatter_nz(IDX_W'($urandom), IDX_W'($urandom), rand_q(), rand_q(), 1023);
        read_entry(10'd1023);
        read_entry(10'd0);
        for (int n = 0; n < 10; n++)
            read_entry(ACC_AW'($urandom));
        clear_marks();
        read_entry(10'd1023);

        wait_idle();
        repeat (30) @(posedge clk);
        if (fail_count == 0 && replies_owed == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
